@@ hdl/sparse_matrix_sorted_table_unit_macros.svh @@
// assertion helpers for the sorted table unit
`ifndef SPARSE_MATRIX_SORTED_TABLE_UNIT_MACROS_SVH
`define SPARSE_MATRIX_SORTED_TABLE_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SMST_ASSERT_IMP(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |-> (rhs)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SMST_ASSERT_NXT(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

@@ hdl/smst_pkg.sv @@
package smst_pkg;

	// table geometry
	localparam int CAPACITY = 256;
	localparam int DIM_MAX  = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DIM_W    = 9;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OOB  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// command codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [1:0] CFG_COL_COUNT = 2'd1;

	typedef struct packed {
		logic               command;
		logic [7:0]         row;
		logic [7:0]         col;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [CNT_W-1:0]   entry_count;
	} result_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] value;
	} entry_t;

endpackage

@@ hdl/smst_ram.sv @@
module smst_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/sparse_matrix_sorted_table_unit.sv @@
// Sparse matrix store: nonzero entries kept in one RAM sorted by (row, col).
// Pulse start while busy is low to issue a read or write; one result follows on
// result, marked by a one-cycle done strobe that the receiver must take then.
// Every in-bounds command first does a binary search over the stored entries,
// each step reading the RAM through its registered read port (S_SRCH, then
// S_CMP) and a closing S_SRCH read before S_HIT. A read or an update then
// goes on to S_DONE. An insert or a removal moves every entry above the
// position by one place, one entry per cycle through the single RAM write port.
// Out-of-bounds commands go from idle straight to S_DONE. Write row_count and
// col_count only while busy is low; cfg_ready is always high.
`include "sparse_matrix_sorted_table_unit_macros.svh"

module sparse_matrix_sorted_table_unit
	import smst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  item_t            item,
	output logic             busy,
	output logic             done,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SRCH = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_HIT  = 3'd3;
	localparam logic [2:0] S_DEL  = 3'd4;
	localparam logic [2:0] S_INS  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]        state_q;
	item_t             item_q;
	logic [DIM_W-1:0]  row_count_q;
	logic [DIM_W-1:0]  col_count_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [CNT_W-1:0]  mid_q;
	logic [CNT_W-1:0]  ptr_q;
	logic              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [31:0]       res_value_q;
	logic [1:0]        res_status_q;

	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  ptr_m1;
	logic [15:0]       key;
	logic [15:0]       rd_key;
	logic              hit;
	logic              in_bounds;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;
	entry_t            new_entry;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] lim;
		lim = DIM_W'(DIM_MAX);
		return (d > lim) ? lim : d;
	endfunction

	// search and shift helpers
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign ptr_m1    = ptr_q - CNT_W'(1);
	assign key       = {item_q.row, item_q.col};
	assign rd_key    = {ram_rdata.row, ram_rdata.col};
	assign hit       = (lo_q < count_q) && (rd_key == key);
	assign new_entry = '{row: item_q.row, col: item_q.col, value: item_q.value};
	assign in_bounds = ({1'b0, item.row} < clamp_dim(row_count_q))
		&& ({1'b0, item.col} < clamp_dim(col_count_q));

	// handshake outputs
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_DONE);
	assign cfg_ready = 1'b1;
	assign result    = '{read_value: res_value_q, status: res_status_q,
		entry_count: count_q};

	// table memory
	smst_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ram port steering
	always_comb begin
		ram_raddr = '0;
		ram_we    = pend_q;
		ram_waddr = pend_addr_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_SRCH: begin
				ram_raddr = (lo_q < hi_q) ? mid[ADDR_W-1:0] : lo_q[ADDR_W-1:0];
			end
			S_HIT: begin
				if (item_q.command == CMD_WRITE && item_q.value != 0 && hit) begin
					ram_we    = 1'b1;
					ram_waddr = lo_q[ADDR_W-1:0];
					ram_wdata = new_entry;
				end
			end
			S_DEL: begin
				if (ptr_q < count_q) begin
					ram_raddr = ptr_q[ADDR_W-1:0];
				end
			end
			S_INS: begin
				if (ptr_q > lo_q) begin
					ram_raddr = ptr_m1[ADDR_W-1:0];
				end else if (!pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = lo_q[ADDR_W-1:0];
					ram_wdata = new_entry;
				end
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_W'(256);
			col_count_q <= DIM_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			item_q <= item;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			mid_q        <= '0;
			ptr_q        <= '0;
			pend_q       <= 1'b0;
			pend_addr_q  <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						res_value_q  <= '0;
						res_status_q <= in_bounds ? ST_OK : ST_OOB;
						lo_q         <= '0;
						hi_q         <= count_q;
						state_q      <= in_bounds ? S_SRCH : S_DONE;
					end
				end
				S_SRCH: begin
					mid_q   <= mid;
					state_q <= (lo_q < hi_q) ? S_CMP : S_HIT;
				end
				S_CMP: begin
					if (rd_key < key) begin
						lo_q <= mid_q + CNT_W'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH;
				end
				S_HIT: begin
					if (item_q.command == CMD_READ) begin
						res_value_q <= hit ? ram_rdata.value : 32'd0;
						state_q     <= S_DONE;
					end else if (item_q.value == 0) begin
						ptr_q   <= lo_q + CNT_W'(1);
						state_q <= hit ? S_DEL : S_DONE;
					end else if (hit) begin
						state_q <= S_DONE;
					end else if (count_q >= CNT_W'(CAPACITY)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_DONE;
					end else begin
						ptr_q   <= count_q;
						state_q <= S_INS;
					end
				end
				S_DEL: begin
					// read entry k+1, write it to k on the next cycle
					if (ptr_q < count_q) begin
						pend_q      <= 1'b1;
						pend_addr_q <= ptr_m1[ADDR_W-1:0];
						ptr_q       <= ptr_q + CNT_W'(1);
					end else begin
						pend_q  <= 1'b0;
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_INS: begin
					// read entry k-1, write it to k on the next cycle
					if (ptr_q > lo_q) begin
						pend_q      <= 1'b1;
						pend_addr_q <= ptr_q[ADDR_W-1:0];
						ptr_q       <= ptr_m1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`SMST_ASSERT_NXT(a_done_to_idle, done, !busy, "result beat not followed by idle")
	`SMST_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted command did not go busy")
	`SMST_ASSERT_IMP(a_full_count, done && result.status == ST_FULL, result.entry_count == CNT_W'(CAPACITY), "full status with room left")
	`SMST_ASSERT_IMP(a_oob_zero, done && result.status == ST_OOB, result.read_value == 0, "out of bounds beat carries a value")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import smst_pkg::*;

	// spare register indexes that the block must ignore
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 300;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start;
	item_t            cmd_item;
	logic             busy;
	logic             done;
	result_t          reply;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [DIM_W-1:0] cfg_data;

	sparse_matrix_sorted_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (cmd_item),
		.busy      (busy),
		.done      (done),
		.result    (reply),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// shadow copy of the matrix store and its dimensions
	entry_t           shadow_tab [CAPACITY];
	int unsigned      shadow_count = 0;
	logic [DIM_W-1:0] dim_rows = 9'd256;
	logic [DIM_W-1:0] dim_cols = 9'd256;

	result_t replies_due [$];
	int      errors = 0;
	int      stall_cycles = 0;
	bit      steady = 1'b0;

	// apply one command to the shadow store and return the reply it owes
	function automatic result_t table_access(input item_t it);
		result_t     res;
		int unsigned row_lim, col_lim, lo, hi, mid, k;
		logic [15:0] key;
		bit          hit;
		res = '0;
		res.status = ST_OK;
		row_lim = (dim_rows > DIM_MAX) ? DIM_MAX : dim_rows;
		col_lim = (dim_cols > DIM_MAX) ? DIM_MAX : dim_cols;
		if (it.row >= row_lim || it.col >= col_lim) begin
			res.status = ST_OOB;
		end else begin
			key = {it.row, it.col};
			lo = 0;
			hi = shadow_count;
			// lower bound over the sorted keys
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if ({shadow_tab[mid].row, shadow_tab[mid].col} < key)
					lo = mid + 1;
				else
					hi = mid;
			end
			hit = (lo < shadow_count) && ({shadow_tab[lo].row, shadow_tab[lo].col} == key);
			if (it.command == CMD_READ) begin
				if (hit)
					res.read_value = shadow_tab[lo].value;
			end else if (it.value == 0) begin
				// removal closes the gap
				if (hit) begin
					for (k = lo; k + 1 < shadow_count; k++)
						shadow_tab[k] = shadow_tab[k + 1];
					shadow_count--;
				end
			end else if (hit) begin
				shadow_tab[lo].value = it.value;
			end else if (shadow_count >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				// insert opens a slot at the lower bound
				for (k = shadow_count; k > lo; k--)
					shadow_tab[k] = shadow_tab[k - 1];
				shadow_tab[lo].row = it.row;
				shadow_tab[lo].col = it.col;
				shadow_tab[lo].value = it.value;
				shadow_count++;
			end
		end
		res.entry_count = CNT_W'(shadow_count);
		return res;
	endfunction

	// issue one command beat; start idles at random cycles unless steady
	task automatic send_cmd(input item_t it);
		bit go;
		cmd_item <= it;
		forever begin
			go = steady || ($urandom_range(99) >= 15);
			start <= go;
			@(posedge clk);
			if (go && !busy)
				break;
		end
		replies_due.push_back(table_access(it));
	endtask

	task automatic access(input logic cmd, input logic [7:0] r, input logic [7:0] c,
			input logic signed [31:0] v);
		item_t it;
		it.command = cmd;
		it.row = r;
		it.col = c;
		it.value = v;
		send_cmd(it);
	endtask

	// stop issuing and wait until every reply is in and the block is idle
	task automatic settle();
		start <= 1'b0;
		do @(negedge clk); while (replies_due.size() != 0 || busy);
		@(posedge clk);
	endtask

	// one register beat; valid is left high for a following beat
	task automatic put_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_ROW_COUNT: dim_rows = data;
			CFG_COL_COUNT: dim_cols = data;
			default: ;
		endcase
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
		settle();
		put_reg(CFG_ROW_COUNT, rows);
		put_reg(CFG_COL_COUNT, cols);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] nonzero_value();
		logic signed [31:0] v;
		v = $urandom;
		if (v == 0)
			v = 1;
		return v;
	endfunction

	// random command, mostly inside a small window so hits are common
	function automatic item_t rand_item(input int row_span, input int col_span);
		item_t it;
		int    pick;
		it.command = ($urandom_range(99) < 40) ? CMD_READ : CMD_WRITE;
		if ($urandom_range(99) < 10) begin
			it.row = 8'($urandom_range(255, 0));
			it.col = 8'($urandom_range(255, 0));
		end else begin
			it.row = 8'($urandom_range(row_span - 1, 0));
			it.col = 8'($urandom_range(col_span - 1, 0));
		end
		pick = $urandom_range(99);
		if (pick < 25)
			it.value = 0;
		else if (pick < 30)
			it.value = 32'sh7fffffff;
		else if (pick < 35)
			it.value = 32'sh80000000;
		else
			it.value = $urandom;
		return it;
	endfunction

	task automatic run_batch(input int n, input int row_span, input int col_span);
		repeat (n) send_cmd(rand_item(row_span, col_span));
	endtask

	// corners of the coordinate and value ranges at reset dimensions
	task automatic test_directed();
		settle();
		access(CMD_READ,  8'd0,   8'd0,   32'sd0);
		access(CMD_WRITE, 8'd0,   8'd0,   32'sh80000000);
		access(CMD_WRITE, 8'd255, 8'd255, 32'sh7fffffff);
		access(CMD_WRITE, 8'd0,   8'd255, -32'sd1);
		access(CMD_WRITE, 8'd255, 8'd0,   32'sd1);
		access(CMD_WRITE, 8'd128, 8'd127, 32'sh5a5a5a5a);
		access(CMD_READ,  8'd0,   8'd0,   32'sd0);
		access(CMD_READ,  8'd255, 8'd255, 32'sd0);
		access(CMD_READ,  8'd0,   8'd255, 32'sd0);
		access(CMD_READ,  8'd255, 8'd0,   32'sd0);
		access(CMD_READ,  8'd128, 8'd127, 32'sd0);
		// update in place
		access(CMD_WRITE, 8'd0,   8'd0,   32'sd7);
		access(CMD_READ,  8'd0,   8'd0,   32'sd0);
		// zero to an absent coordinate leaves the table alone
		access(CMD_WRITE, 8'd10,  8'd10,  32'sd0);
		// removal
		access(CMD_WRITE, 8'd0,   8'd255, 32'sd0);
		access(CMD_READ,  8'd0,   8'd255, 32'sd0);
		access(CMD_WRITE, 8'd128, 8'd127, 32'sd0);
		settle();
	endtask

	// dimension registers: zero, one, past the maximum, spare indexes
	task automatic test_bounds();
		set_dims(9'd0, 9'd256);
		access(CMD_READ,  8'd0, 8'd0, 32'sd0);
		access(CMD_WRITE, 8'd0, 8'd0, 32'sd99);
		set_dims(9'd256, 9'd0);
		access(CMD_WRITE, 8'd0, 8'd0, 32'sd0);
		set_dims(9'd1, 9'd1);
		access(CMD_WRITE, 8'd0, 8'd0, 32'sd11);
		access(CMD_READ,  8'd1, 8'd0, 32'sd0);
		access(CMD_WRITE, 8'd0, 8'd1, 32'sd12);
		access(CMD_READ,  8'd0, 8'd0, 32'sd0);
		set_dims(9'd511, 9'd300);
		access(CMD_READ,  8'd255, 8'd255, 32'sd0);
		access(CMD_WRITE, 8'd255, 8'd255, 32'sh7ffffffe);
		// writes to spare indexes change nothing
		settle();
		put_reg(CFG_SPARE_A, 9'd0);
		put_reg(CFG_SPARE_B, 9'd511);
		cfg_valid <= 1'b0;
		access(CMD_READ,  8'd255, 8'd255, 32'sd0);
		access(CMD_READ,  8'd0,   8'd0,   32'sd0);
		set_dims(9'd256, 9'd256);
	endtask

	// fill the table, then hit the full case with insert, update and removal
	task automatic test_full();
		logic [7:0] keys [256];
		logic [7:0] tmp;
		int         i, j;
		for (i = 0; i < 256; i++)
			keys[i] = i[7:0];
		for (i = 255; i > 0; i--) begin
			j = $urandom_range(i, 0);
			tmp = keys[i];
			keys[i] = keys[j];
			keys[j] = tmp;
		end
		// clear corner entries left by earlier tests
		access(CMD_WRITE, 8'd255, 8'd255, 32'sd0);
		access(CMD_WRITE, 8'd255, 8'd0,   32'sd0);
		for (i = 0; i < 256; i++)
			access(CMD_WRITE, {4'd0, keys[i][7:4]}, {4'd0, keys[i][3:0]}, nonzero_value());
		access(CMD_WRITE, 8'd200, 8'd200, 32'sd9);
		access(CMD_READ,  8'd200, 8'd200, 32'sd0);
		access(CMD_WRITE, 8'd3,   8'd3,   32'sh80000000);
		access(CMD_READ,  8'd3,   8'd3,   32'sd0);
		access(CMD_WRITE, 8'd5,   8'd5,   32'sd0);
		access(CMD_WRITE, 8'd200, 8'd200, 32'sd9);
		access(CMD_WRITE, 8'd201, 8'd201, 32'sd10);
		access(CMD_READ,  8'd200, 8'd200, 32'sd0);
		settle();
	endtask

	// random traffic over several dimension settings
	task automatic test_random();
		set_dims(9'd256, 9'd256);
		run_batch(200, 16, 16);
		set_dims(9'd20, 9'd12);
		steady = 1'b1;
		run_batch(200, 24, 16);
		steady = 1'b0;
		set_dims(9'd1, 9'd256);
		run_batch(100, 2, 32);
		set_dims(9'd256, 9'd1);
		run_batch(100, 32, 2);
		set_dims(9'd300, 9'd511);
		run_batch(200, 8, 8);
		settle();
	endtask

	// compare each reply beat with the oldest prediction
	always @(posedge clk) begin : check_replies
		result_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: unexpected reply value %0d status %0d count %0d", $time,
					reply.read_value, reply.status, reply.entry_count);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (reply.read_value !== want.read_value) begin
					$display("%0t: read_value expected %0d got %0d", $time,
						want.read_value, reply.read_value);
					errors++;
				end
				if (reply.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, reply.status);
					errors++;
				end
				if (reply.entry_count !== want.entry_count) begin
					$display("%0t: entry_count expected %0d got %0d", $time,
						want.entry_count, reply.entry_count);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat of any kind
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		start = 1'b0;
		cmd_item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_bounds();
		test_full();
		test_random();
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ sparse_matrix_sorted_table_unit.f @@
+incdir+hdl
hdl/smst_pkg.sv
hdl/smst_ram.sv
hdl/sparse_matrix_sorted_table_unit.sv
verif/tb_top.sv
